// ===== rtl/tccl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_pkg
// Shared types, codes and helpers for the text console cursor layout block.
// ----------------------------------------------------------------------------
package tccl_pkg;

  // character codes with special handling
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  // job queue geometry
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // positions in a job's command mask, emitted lowest first
  localparam int JB_FILL = 0;
  localparam int JB_OVF  = 1;
  localparam int JB_DRAW = 2;

  // drawing command codes
  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DRAW   = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_AREA_WIDTH    = 3'd2,
    CFG_BOTTOM_LINE_Y = 3'd3,
    CFG_LINE_HEIGHT   = 3'd4,
    CFG_CHAR_PADDING  = 3'd5,
    CFG_SCROLL_ENABLE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] area_width;
    logic [11:0] bottom_line_y;
    logic [7:0]  line_height;
    logic [7:0]  char_padding;
    logic        scroll_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] glyph_width;
  } in_item_t;

  typedef struct packed {
    cmd_t        command;
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [11:0] area_w;
    logic [12:0] area_h;
    logic [7:0]  glyph_code;
    logic        last;
  } out_item_t;

  // one classified item: every command it causes, fully resolved
  typedef struct packed {
    logic [2:0]  mask;
    logic [12:0] fill_x;
    logic [12:0] fill_y;
    logic [11:0] fill_w;
    logic [7:0]  fill_h;
    cmd_t        ovf_cmd;
    logic [11:0] ovf_x;
    logic [11:0] ovf_y;
    logic [11:0] ovf_w;
    logic [12:0] ovf_h;
    logic [12:0] draw_x;
    logic [12:0] draw_y;
    logic [7:0]  glyph;
  } job_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  // clamp a 14-bit sum to 13 bits
  function automatic logic [12:0] sat13(input logic [13:0] v);
    logic [12:0] r;
    r = v[13] ? 13'h1FFF : v[12:0];
    return r;
  endfunction

endpackage

// ===== rtl/text_console_cursor_layout.sv =====
`timescale 1ns / 1ps
// path: an item goes through the job queue, the back end's job register and the output
//   register; earlier items with commands still waiting or stalled hold it back
// throughput: one item per cycle at the input while the 2-deep job queue has room;
//   commands leave one per cycle while out_ready does not stall them, 0 to 3 per item
// reset: synchronous, active low; cursor at 0, queue and output empty, registers
//   at their documented defaults
// ----------------------------------------------------------------------------
// text_console_cursor_layout
// Keeps a pixel cursor in a console area and emits fill, scroll, clear and
// draw commands for each character item.
// ----------------------------------------------------------------------------
module text_console_cursor_layout import tccl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  cfg_t    cfg_r;
  job_t    job, head;
  logic    push, pop;
  q_stat_t q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= 12'd0;
      cfg_r.origin_y      <= 12'd0;
      cfg_r.area_width    <= 12'd320;
      cfg_r.bottom_line_y <= 12'd224;
      cfg_r.line_height   <= 8'd16;
      cfg_r.char_padding  <= 8'd1;
      cfg_r.scroll_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata;
        CFG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata;
        CFG_AREA_WIDTH:    cfg_r.area_width    <= cfg_wdata;
        CFG_BOTTOM_LINE_Y: cfg_r.bottom_line_y <= cfg_wdata;
        CFG_LINE_HEIGHT:   cfg_r.line_height   <= cfg_wdata[7:0];
        CFG_CHAR_PADDING:  cfg_r.char_padding  <= cfg_wdata[7:0];
        CFG_SCROLL_ENABLE: cfg_r.scroll_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // classify items and track the cursor
  tccl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_stat.full),
    .push     (push),
    .job      (job)
  );

  // job queue
  tccl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // command sequencer and output register
  tccl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count <= QCW'(QDEPTH)) && (q_stat.empty == (q_stat.count == '0)))
    else $error("job queue level out of range");

  a_cr_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.char_code == CH_RETURN)) |-> !push)
    else $error("carriage return produced a job");

  a_draw_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.command == CMD_DRAW)) |->
      ((out_data.area_w == '0) && (out_data.area_h == '0) && out_data.last))
    else $error("draw command with area fields set or not last");

  a_area_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.command != CMD_DRAW)) |-> (out_data.glyph_code == '0))
    else $error("area command carries a glyph code");

endmodule

// ===== rtl/tccl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_front
// Accepts items, tracks the pixel cursor and turns each item into a job.
// ----------------------------------------------------------------------------
module tccl_front import tccl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output job_t     job
);

  logic [12:0] cur_x_r, cur_x_nxt;
  logic [12:0] cur_y_r, cur_y_nxt;

  logic        acc, is_nl, is_cr;
  logic        fits_x, wrap, fill_en, ovf;
  logic [8:0]  adv_w;
  logic [13:0] x_end;
  logic [12:0] cy_step, cx1, cy1, cx2, cy2;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_nl    = (in_data.char_code == CH_NEWLINE);
  assign is_cr    = (in_data.char_code == CH_RETURN);

  // wrap, overflow and cursor arithmetic
  always_comb begin
    fits_x  = cur_x_r < {1'b0, cfg.area_width};
    adv_w   = {1'b0, in_data.glyph_width} + {1'b0, cfg.char_padding};
    x_end   = {1'b0, cur_x_r} + {5'b0, adv_w};
    wrap    = x_end >= {2'b0, cfg.area_width};
    cy_step = sat13({1'b0, cur_y_r} + {6'b0, cfg.line_height});
    if (is_nl) begin
      fill_en = fits_x;
    end else begin
      fill_en = wrap && (cur_y_r <= {1'b0, cfg.bottom_line_y}) && fits_x;
    end
    cx1 = wrap ? 13'd0 : cur_x_r;
    cy1 = wrap ? cy_step : cur_y_r;
    ovf = cy1 > {1'b0, cfg.bottom_line_y};
    cx2 = ovf ? 13'd0 : cx1;
    if (ovf) begin
      cy2 = cfg.scroll_enable ? {1'b0, cfg.bottom_line_y} : 13'd0;
    end else begin
      cy2 = cy1;
    end
  end

  // job record
  always_comb begin
    job.fill_x  = sat13({2'b0, cfg.origin_x} + {1'b0, cur_x_r});
    job.fill_y  = sat13({2'b0, cfg.origin_y} + {1'b0, cur_y_r});
    job.fill_w  = cfg.area_width - cur_x_r[11:0];
    job.fill_h  = cfg.line_height;
    job.ovf_cmd = cfg.scroll_enable ? CMD_SCROLL : CMD_CLEAR;
    job.ovf_x   = cfg.origin_x;
    job.ovf_y   = cfg.origin_y;
    job.ovf_w   = cfg.area_width;
    job.ovf_h   = {1'b0, cfg.bottom_line_y} + {5'b0, cfg.line_height};
    job.draw_x  = sat13({2'b0, cfg.origin_x} + {1'b0, cx2});
    job.draw_y  = sat13({2'b0, cfg.origin_y} + {1'b0, cy2});
    job.glyph   = in_data.char_code;
    job.mask    = '0;
    job.mask[JB_FILL] = fill_en;
    job.mask[JB_OVF]  = !is_nl && ovf;
    job.mask[JB_DRAW] = !is_nl;
  end

  // items that cause no command never enter the queue
  assign push = acc && !is_cr && (!is_nl || fill_en);

  // cursor update
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (acc && !is_cr) begin
      if (is_nl) begin
        cur_x_nxt = 13'd0;
        cur_y_nxt = cy_step;
      end else begin
        cur_x_nxt = sat13({1'b0, cx2} + {5'b0, adv_w});
        cur_y_nxt = cy2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule

// ===== rtl/tccl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_queue
// Short job queue between the classifying front and the command back end.
// ----------------------------------------------------------------------------
module tccl_queue import tccl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (count_r == QCW'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head       = slot_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/tccl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_back
// Takes jobs from the queue and emits their commands, one per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module tccl_back import tccl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  job_t      job_r, job_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic       adv, emit;
  logic [2:0] sel, rem;
  out_item_t  cmd;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the next pending command of the current job
  always_comb begin
    adv  = !out_valid_r || out_ready;
    emit = adv && (pend_r != 3'b000);
    sel  = pend_r & (~pend_r + 3'b001);
    rem  = emit ? (pend_r & ~sel) : pend_r;
  end

  // build the command word
  always_comb begin
    cmd            = '0;
    cmd.last       = (rem == 3'b000);
    if (sel[JB_FILL]) begin
      cmd.command  = CMD_FILL;
      cmd.pos_x    = job_r.fill_x;
      cmd.pos_y    = job_r.fill_y;
      cmd.area_w   = job_r.fill_w;
      cmd.area_h   = {5'b0, job_r.fill_h};
    end else if (sel[JB_OVF]) begin
      cmd.command  = job_r.ovf_cmd;
      cmd.pos_x    = {1'b0, job_r.ovf_x};
      cmd.pos_y    = {1'b0, job_r.ovf_y};
      cmd.area_w   = job_r.ovf_w;
      cmd.area_h   = job_r.ovf_h;
    end else begin
      cmd.command  = CMD_DRAW;
      cmd.pos_x    = job_r.draw_x;
      cmd.pos_y    = job_r.draw_y;
      cmd.glyph_code = job_r.glyph;
    end
  end

  // load the next job as the current one runs out
  always_comb begin
    pop      = (rem == 3'b000) && !q_empty;
    job_nxt  = pop ? head : job_r;
    pend_nxt = pop ? head.mask : rem;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cmd;
    end else begin
      out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
